>>> rtl/bssd_pkg.sv
package bssd_pkg;

  localparam int OP_W       = 2;
  localparam int VI_W       = 12;
  localparam int BID_W      = 10;
  localparam int LID_W      = 4;
  localparam int VAL_W      = 32;
  localparam int RES_W      = 48;
  localparam int ST_W       = 2;
  localparam int COEF_W     = 24;
  localparam int CNT_W      = 11;
  localparam int SZ_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GROUPS     = 3;
  localparam int BASE_W     = 13;
  localparam int EW         = 18;
  localparam int MB_W       = 17;
  localparam int DIM_W      = 7;
  localparam int MUL_W      = 33;
  localparam int SUM_W      = 64;

  localparam int DEF_VECTOR_DEPTH  = 4096;
  localparam int DEF_MAX_BLOCK_DIM = 16;
  localparam int DEF_GROUP_COUNT   = 3;
  localparam int DEF_MAX_BLOCKS    = 1024;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_MAC   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G0_BLOCKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_G0_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_G1_BLOCKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_G1_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_G2_BLOCKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_G2_SIZE   = 3'd6;

  typedef struct packed {
    logic [GROUPS-1:0][CNT_W-1:0] blocks;
    logic [GROUPS-1:0][SZ_W-1:0]  size;
  } grp_cfg_t;

  typedef struct packed {
    logic            ok;
    logic [EW-1:0]   off;
    logic [SZ_W-1:0] size;
  } loc_t;

endpackage

>>> rtl/bssd_if.sv
interface bssd_req_if import bssd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [VI_W-1:0]         vec_index;
  logic [BID_W-1:0]        block_row;
  logic [BID_W-1:0]        block_col;
  logic [LID_W-1:0]        local_row;
  logic [LID_W-1:0]        local_col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, op, vec_index, block_row, block_col, local_row, local_col,
                  value, input ready);
  modport sink (input valid, op, vec_index, block_row, block_col, local_row, local_col,
                value, output ready);
endinterface

interface bssd_rsp_if import bssd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [VI_W-1:0]         result_index;
  logic [ST_W-1:0]         status;

  modport source (output valid, result_value, result_index, status, input ready);
  modport sink (input valid, result_value, result_index, status, output ready);
endinterface

>>> rtl/block_sym_spmv_damped.sv
// Damped product y = A*x for a symmetric block-sparse matrix given by its upper blocks, in
// Q16.16 with saturating 48-bit accumulation. Each word is worked in turn by the sequencer
// through the block locator, the one shared multiplier and the single read and write port
// of the result memory. A read word also waits on the result side; a rejected matrix
// element ends after the bound check, an accepted element on the diagonal is first damped,
// and one in an off-diagonal block is added into the result memory twice, at its row and
// at its column. A clear word and reset start a pass that zeroes the result memory, during
// which no word is accepted; configuration writes are taken at any time.
module block_sym_spmv_damped import bssd_pkg::*; #(
  parameter int VECTOR_DEPTH  = DEF_VECTOR_DEPTH,
  parameter int MAX_BLOCK_DIM = DEF_MAX_BLOCK_DIM,
  parameter int GROUP_COUNT   = DEF_GROUP_COUNT,
  parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bssd_req_if.sink              req_i,
  bssd_rsp_if.source            rsp_o
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_XWR   = 4'd1;
  localparam logic [3:0] ST_LOCR  = 4'd2;
  localparam logic [3:0] ST_LOCC  = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_DAMP  = 4'd5;
  localparam logic [3:0] ST_DAMPW = 4'd6;
  localparam logic [3:0] ST_MUL1  = 4'd7;
  localparam logic [3:0] ST_ACC1  = 4'd8;
  localparam logic [3:0] ST_YRD2  = 4'd9;
  localparam logic [3:0] ST_ACC2  = 4'd10;
  localparam logic [3:0] ST_RD    = 4'd11;
  localparam logic [3:0] ST_RDW   = 4'd12;
  localparam logic [3:0] ST_CLR   = 4'd13;

  localparam logic signed [RES_W-1:0] DAMP_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [RES_W-1:0] DAMP_MIN = 48'shFFFF_8000_0000;
  localparam logic signed [RES_W-1:0] Y_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] Y_MIN    = 48'sh8000_0000_0000;
  localparam logic [MUL_W-1:0]        DAMP_ONE = 33'h0_0001_0000;

  logic [COEF_W-1:0] coef_q;
  grp_cfg_t          grp_q;

  logic [3:0]              state_d, state_q;
  logic [VI_W-1:0]         vi_d, vi_q;
  logic [BID_W-1:0]        br_d, br_q, bc_d, bc_q;
  logic [LID_W-1:0]        lr_d, lr_q, lc_d, lc_q;
  logic signed [VAL_W-1:0] val_d, val_q;
  loc_t                    rloc_d, rloc_q, cloc_d, cloc_q;
  logic [AW-1:0]           i_d, i_q, j_d, j_q, clr_d, clr_q;
  logic [ST_W-1:0]         status_d, status_q;

  logic                    out_valid_d, out_valid_q;
  logic signed [RES_W-1:0] out_value_d, out_value_q;
  logic [VI_W-1:0]         out_index_d, out_index_q;
  logic [ST_W-1:0]         out_status_d, out_status_q;

  logic                    x_we, x_re, y_we, y_re;
  logic [AW-1:0]           x_waddr, x_raddr, y_waddr, y_raddr;
  logic signed [VAL_W-1:0] x_wdata, x_rd_q;
  logic signed [RES_W-1:0] y_wdata, y_rd_q;
  logic signed [VAL_W-1:0] x_mem [VECTOR_DEPTH];
  logic signed [RES_W-1:0] y_mem [VECTOR_DEPTH];

  logic                    mul_en;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [RES_W-1:0] rnd;
  logic [BID_W-1:0]        loc_id;
  loc_t                    loc;

  logic                    accept, out_free, vi_ok, bad, diag, acc_sat;
  logic [EW-1:0]           i_full, j_full;
  logic [RES_W:0]          acc_sum;
  logic signed [RES_W-1:0] acc_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        grp_q.blocks[g] <= '0;
        grp_q.size[g]   <= SZ_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COEF:      coef_q          <= cfg_wdata_i[COEF_W-1:0];
        REG_G0_BLOCKS: grp_q.blocks[0] <= cfg_wdata_i[CNT_W-1:0];
        REG_G0_SIZE:   grp_q.size[0]   <= cfg_wdata_i[SZ_W-1:0];
        REG_G1_BLOCKS: grp_q.blocks[1] <= cfg_wdata_i[CNT_W-1:0];
        REG_G1_SIZE:   grp_q.size[1]   <= cfg_wdata_i[SZ_W-1:0];
        REG_G2_BLOCKS: grp_q.blocks[2] <= cfg_wdata_i[CNT_W-1:0];
        REG_G2_SIZE:   grp_q.size[2]   <= cfg_wdata_i[SZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bssd_locate #(
    .GROUP_COUNT (GROUP_COUNT),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_locate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (grp_q),
    .id_i   (loc_id),
    .loc_o  (loc)
  );

  bssd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .rnd_o (rnd)
  );

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    if (x_re) begin
      x_rd_q <= x_mem[x_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_we) begin
      y_mem[y_waddr] <= y_wdata;
    end
    if (y_re) begin
      y_rd_q <= y_mem[y_raddr];
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign accept             = req_i.valid && req_i.ready;
  assign out_free           = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.result_index = out_index_q;
  assign rsp_o.status       = out_status_q;

  assign vi_ok  = EW'(vi_q) < EW'(VECTOR_DEPTH);
  assign i_full = rloc_q.off + EW'(lr_q);
  assign j_full = cloc_q.off + EW'(lc_q);
  assign diag   = (br_q == bc_q) && (lr_q == lc_q);
  assign bad    = !rloc_q.ok || !cloc_q.ok
               || (DIM_W'(rloc_q.size) > DIM_W'(MAX_BLOCK_DIM))
               || (DIM_W'(cloc_q.size) > DIM_W'(MAX_BLOCK_DIM))
               || (SZ_W'(lr_q) >= rloc_q.size) || (SZ_W'(lc_q) >= cloc_q.size)
               || (i_full >= EW'(VECTOR_DEPTH)) || (j_full >= EW'(VECTOR_DEPTH));

  // Saturating add of the rounded product into the entry just read.
  always_comb begin
    acc_sum = {y_rd_q[RES_W-1], y_rd_q} + {rnd[RES_W-1], rnd};
    acc_sat = acc_sum[RES_W] != acc_sum[RES_W-1];
    if (acc_sat) begin
      acc_val = acc_sum[RES_W] ? Y_MIN : Y_MAX;
    end else begin
      acc_val = acc_sum[RES_W-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    vi_d         = vi_q;
    br_d         = br_q;
    bc_d         = bc_q;
    lr_d         = lr_q;
    lc_d         = lc_q;
    val_d        = val_q;
    rloc_d       = rloc_q;
    cloc_d       = cloc_q;
    i_d          = i_q;
    j_d          = j_q;
    clr_d        = clr_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_index_d  = out_index_q;
    out_status_d = out_status_q;
    x_we         = 1'b0;
    x_waddr      = '0;
    x_wdata      = val_q;
    x_re         = 1'b0;
    x_raddr      = '0;
    y_we         = 1'b0;
    y_waddr      = '0;
    y_wdata      = acc_val;
    y_re         = 1'b0;
    y_raddr      = '0;
    mul_en       = 1'b0;
    mul_a        = MUL_W'(val_q);
    mul_b        = MUL_W'(x_rd_q);
    loc_id       = br_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          vi_d  = req_i.vec_index;
          br_d  = req_i.block_row;
          bc_d  = req_i.block_col;
          lr_d  = req_i.local_row;
          lc_d  = req_i.local_col;
          val_d = req_i.value;
          case (req_i.op)
            OP_LOAD: state_d = ST_XWR;
            OP_MAC:  state_d = ST_LOCR;
            OP_READ: state_d = ST_RD;
            OP_CLEAR: begin
              state_d  = ST_CLR;
              clr_d    = '0;
              status_d = '0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_XWR: begin
        if (vi_ok) begin
          x_we    = 1'b1;
          x_waddr = AW'(EW'(vi_q));
        end else begin
          status_d[0] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_LOCR: begin
        loc_id  = br_q;
        rloc_d  = loc;
        state_d = ST_LOCC;
      end
      ST_LOCC: begin
        loc_id  = bc_q;
        cloc_d  = loc;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (bad) begin
          status_d[0] = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          i_d     = i_full[AW-1:0];
          j_d     = j_full[AW-1:0];
          x_re    = 1'b1;
          x_raddr = j_full[AW-1:0];
          state_d = diag ? ST_DAMP : ST_MUL1;
        end
      end
      ST_DAMP: begin
        mul_en  = 1'b1;
        mul_b   = DAMP_ONE + MUL_W'(coef_q);
        state_d = ST_DAMPW;
      end
      ST_DAMPW: begin
        if (rnd > DAMP_MAX) begin
          val_d       = DAMP_MAX[VAL_W-1:0];
          status_d[1] = 1'b1;
        end else if (rnd < DAMP_MIN) begin
          val_d       = DAMP_MIN[VAL_W-1:0];
          status_d[1] = 1'b1;
        end else begin
          val_d = rnd[VAL_W-1:0];
        end
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        mul_en  = 1'b1;
        x_re    = 1'b1;
        x_raddr = i_q;
        y_re    = 1'b1;
        y_raddr = i_q;
        state_d = ST_ACC1;
      end
      ST_ACC1: begin
        y_we    = 1'b1;
        y_waddr = i_q;
        if (acc_sat) begin
          status_d[1] = 1'b1;
        end
        if (br_q != bc_q) begin
          mul_en  = 1'b1;
          state_d = ST_YRD2;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_YRD2: begin
        y_re    = 1'b1;
        y_raddr = j_q;
        state_d = ST_ACC2;
      end
      ST_ACC2: begin
        y_we    = 1'b1;
        y_waddr = j_q;
        if (acc_sat) begin
          status_d[1] = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_RD: begin
        if (vi_ok) begin
          y_re    = 1'b1;
          y_raddr = AW'(EW'(vi_q));
        end else begin
          status_d[0] = 1'b1;
        end
        state_d = ST_RDW;
      end
      ST_RDW: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = vi_ok ? y_rd_q : '0;
          out_index_d  = vi_q;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      ST_CLR: begin
        y_we    = 1'b1;
        y_waddr = clr_q;
        y_wdata = '0;
        if (clr_q == AW'(VECTOR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vi_q         <= vi_d;
    br_q         <= br_d;
    bc_q         <= bc_d;
    lr_q         <= lr_d;
    lc_q         <= lc_d;
    val_q        <= val_d;
    rloc_q       <= rloc_d;
    cloc_q       <= cloc_d;
    i_q          <= i_d;
    j_q          <= j_d;
    out_value_q  <= out_value_d;
    out_index_q  <= out_index_d;
    out_status_q <= out_status_d;
  end

endmodule

>>> rtl/bssd_locate.sv
module bssd_locate import bssd_pkg::*; #(
  parameter int GROUP_COUNT = DEF_GROUP_COUNT,
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grp_cfg_t         cfg_i,
  input  logic [BID_W-1:0] id_i,
  output loc_t             loc_o
);

  logic [GROUPS-1:0][BASE_W-1:0] base_d, base_q, end_d, end_q;
  logic [GROUPS-1:0][EW-1:0]     eoff_d, eoff_q;

  // Group start ids and entry offsets are running sums of the group settings.
  always_comb begin
    logic [BASE_W-1:0] b;
    logic [EW-1:0]     e;
    b = '0;
    e = '0;
    for (int g = 0; g < GROUPS; g++) begin
      base_d[g] = b;
      eoff_d[g] = e;
      b = b + BASE_W'(cfg_i.blocks[g]);
      end_d[g] = b;
      e = e + EW'(cfg_i.blocks[g]) * EW'(cfg_i.size[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      end_q  <= '0;
      eoff_q <= '0;
    end else begin
      base_q <= base_d;
      end_q  <= end_d;
      eoff_q <= eoff_d;
    end
  end

  always_comb begin
    logic              found;
    logic [BASE_W-1:0] sel_base;
    logic [EW-1:0]     sel_eoff;
    logic [SZ_W-1:0]   sel_size;
    logic [BID_W-1:0]  diff;
    found    = 1'b0;
    sel_base = '0;
    sel_eoff = '0;
    sel_size = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (!found && (g < GROUP_COUNT) && (BASE_W'(id_i) < end_q[g])) begin
        found    = 1'b1;
        sel_base = base_q[g];
        sel_eoff = eoff_q[g];
        sel_size = cfg_i.size[g];
      end
    end
    diff       = BID_W'(BASE_W'(id_i) - sel_base);
    loc_o.ok   = found && (MB_W'(id_i) < MB_W'(MAX_BLOCKS));
    loc_o.off  = sel_eoff + EW'(diff) * EW'(sel_size);
    loc_o.size = sel_size;
  end

endmodule

>>> rtl/bssd_mul.sv
module bssd_mul import bssd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [RES_W-1:0] rnd_o
);

  logic signed [2*MUL_W-1:0] prod_q;
  logic signed [SUM_W-1:0]   biased;
  logic signed [SUM_W-1:0]   shifted;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // Round half up to sixteen fraction bits.
  always_comb begin
    biased  = $signed(prod_q[SUM_W-1:0]) + 64'sd32768;
    shifted = biased >>> 16;
    rnd_o   = shifted[RES_W-1:0];
  end

endmodule
